@@ rtl/mcma_pkg.sv @@
package mcma_pkg;

    // Fixed field widths of the request, result and configuration channels.
    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 2;
    localparam int CFG_W    = 7;

    // Window length after reset, before any configuration write.
    localparam int WINDOW_RESET = 8;

    // Saturation limits of the average, as magnitudes.
    localparam int AVG_POS_MAX = 32767;
    localparam int AVG_NEG_MAX = 32768;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } mcma_state_t;

endpackage

@@ rtl/mcma_ram.sv @@
module mcma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/multichannel_moving_average_unit.sv @@
// Channel   Direction  Handshake         Payload
// s_        in         s_valid/s_ready   s_sample, s_channel, s_vector_end
// m_        out        m_valid/m_ready   m_average, m_out_channel, m_out_vector_end
// cfg_      in         cfg_we            cfg_wdata (window length)
//
// Each request passes through accept, ring read, sum update, the bit-serial restoring divider
// at one quotient bit per cycle, and write-out, which waits until the output register is free.
// One request is in flight at a time.
// Reset clears the channel sums, fill count and ring position and sets the window to 8.
// The sample ring is not cleared: the user must see that each entry is written before it is read;
// the block does not enforce this. A result held on a stalled m_ channel keeps the block from
// taking the next request only once the following result is ready to be written out.
module multichannel_moving_average_unit
    import mcma_pkg::*;
#(
    parameter int CHANNELS   = 4,
    parameter int MAX_WINDOW = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_we,
    input  logic [CFG_W-1:0]           cfg_wdata,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic [CHAN_W-1:0]          s_channel,
    input  logic                       s_vector_end,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_average,
    output logic [CHAN_W-1:0]          m_out_channel,
    output logic                       m_out_vector_end
);

    localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
    localparam int POS_W   = $clog2(MAX_WINDOW);
    localparam int DEPTH   = MAX_WINDOW * CHANNELS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CIDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W   = $clog2(SUM_W);
    localparam int WIN_RST = (MAX_WINDOW < WINDOW_RESET) ? MAX_WINDOW : WINDOW_RESET;

    mcma_state_t state_reg, state_next;

    logic [FILL_W-1:0]          window_reg;
    logic [FILL_W-1:0]          window_next;
    logic [FILL_W-1:0]          fill_reg;
    logic [POS_W-1:0]           pos_reg;
    logic signed [SUM_W-1:0]    sums_reg [CHANNELS];

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [CHAN_W-1:0]          chan_reg;
    logic                       vend_reg;

    logic [SUM_W-1:0]           quo_reg;
    logic [FILL_W-1:0]          rem_reg;
    logic [FILL_W-1:0]          count_reg;
    logic                       neg_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] avg_out_reg;
    logic [CHAN_W-1:0]          chan_out_reg;
    logic                       vend_out_reg;

    logic                       accept;
    logic                       out_free;
    logic                       load_out;
    logic                       do_update;
    logic                       do_step;
    logic                       chan_ok;
    logic [CIDX_W-1:0]          chan_idx;
    logic [ADDR_W-1:0]          slot_addr;
    logic [SAMPLE_W-1:0]        ring_rdata;
    logic                       ring_we;

    logic                       full;
    logic [FILL_W-1:0]          count_next;
    logic signed [SUM_W-1:0]    sum_old;
    logic signed [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]           mag_next;

    logic [FILL_W:0]            rem_shift;
    logic                       quo_bit;
    logic [FILL_W-1:0]          rem_next;
    logic [SUM_W-1:0]           quo_next;
    logic signed [SAMPLE_W-1:0] avg_sat;

    logic [POS_W:0]             pos_inc;

    // The configured window is clamped to one up to the largest window.
    always_comb begin
        if (cfg_wdata == '0) begin
            window_next = FILL_W'(1);
        end else if (32'(cfg_wdata) > MAX_WINDOW) begin
            window_next = FILL_W'(MAX_WINDOW);
        end else begin
            window_next = FILL_W'(cfg_wdata);
        end
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        s_ready   = 1'b0;
        do_update = 1'b0;
        do_step   = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready   = 1'b1;
            ST_READ:   ;
            ST_UPDATE: do_update = 1'b1;
            ST_DIVIDE: do_step   = 1'b1;
            ST_DONE:   load_out  = out_free;
            default:   ;
        endcase
    end

    assign accept = s_valid && s_ready;

    // Ring slot of the held request; channels beyond the channel count write no ring entry and no sum.
    assign chan_ok   = 32'(chan_reg) < CHANNELS;
    assign chan_idx  = CIDX_W'(chan_reg);
    assign slot_addr = ADDR_W'(pos_reg) * ADDR_W'(CHANNELS) + ADDR_W'(chan_reg);
    assign ring_we   = do_update && chan_ok;

    mcma_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (ring_we),
        .waddr(slot_addr),
        .wdata(sample_reg),
        .raddr(slot_addr),
        .rdata(ring_rdata)
    );

    // Running sum update: drop the oldest sample once the window is full.
    assign full       = fill_reg >= window_reg;
    assign count_next = full ? window_reg : fill_reg + FILL_W'(1);

    always_comb begin
        sum_old  = chan_ok ? sums_reg[chan_idx] : '0;
        sum_next = sum_old + SUM_W'(sample_reg);
        if (full) begin
            sum_next = sum_next - SUM_W'($signed(ring_rdata));
        end
        if (!chan_ok) begin
            mag_next = '0;
        end else if (sum_next[SUM_W-1]) begin
            mag_next = ~sum_next + SUM_W'(1);
        end else begin
            mag_next = sum_next;
        end
    end

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign quo_bit   = rem_shift >= {1'b0, count_reg};
    assign rem_next  = quo_bit ? FILL_W'(rem_shift - {1'b0, count_reg}) : FILL_W'(rem_shift);
    assign quo_next  = {quo_reg[SUM_W-2:0], quo_bit};

    // Sign and saturation of the finished quotient.
    always_comb begin
        if (!neg_reg) begin
            if (quo_reg > SUM_W'(AVG_POS_MAX)) begin
                avg_sat = SAMPLE_W'(AVG_POS_MAX);
            end else begin
                avg_sat = quo_reg[SAMPLE_W-1:0];
            end
        end else begin
            if (quo_reg > SUM_W'(AVG_NEG_MAX)) begin
                avg_sat = SAMPLE_W'(AVG_NEG_MAX);
            end else begin
                avg_sat = ~quo_reg[SAMPLE_W-1:0] + SAMPLE_W'(1);
            end
        end
    end

    assign pos_inc = {1'b0, pos_reg} + (POS_W + 1)'(1);

    // Control state: sequencer, window, fill count, ring position, sums and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= FILL_W'(WIN_RST);
            fill_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                sums_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                window_reg <= window_next;
                fill_reg   <= '0;
                pos_reg    <= '0;
                for (int i = 0; i < CHANNELS; i++) begin
                    sums_reg[i] <= '0;
                end
            end else if (do_update) begin
                if (chan_ok) begin
                    sums_reg[chan_idx] <= sum_next;
                end
                if (vend_reg) begin
                    if ((FILL_W + 1)'(pos_inc) >= (FILL_W + 1)'(window_reg)) begin
                        pos_reg <= '0;
                    end else begin
                        pos_reg <= pos_inc[POS_W-1:0];
                    end
                    if (fill_reg < window_reg) begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: held request, divider and output register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
            chan_reg   <= s_channel;
            vend_reg   <= s_vector_end;
        end
        if (do_update) begin
            quo_reg   <= mag_next;
            rem_reg   <= '0;
            count_reg <= count_next;
            neg_reg   <= sum_next[SUM_W-1] && chan_ok;
            cnt_reg   <= '0;
        end else if (do_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (load_out) begin
            avg_out_reg  <= avg_sat;
            chan_out_reg <= chan_reg;
            vend_out_reg <= vend_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_average        = avg_out_reg;
    assign m_out_channel    = chan_out_reg;
    assign m_out_vector_end = vend_out_reg;

endmodule

@@ verif/tb.sv @@
module tb
    import mcma_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH     = 4;
    localparam int WIN_MAX    = 64;
    localparam int SUM_W      = 22;
    localparam int LONG_HOLD  = 400;
    localparam int QUIET_MAX  = 3000;
    localparam int ITEM_COUNT = 1800;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          channel;
        logic                       vector_end;
    } sample_req_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] average;
        logic [CHAN_W-1:0]          channel;
        logic                       vector_end;
    } average_res_t;

    logic                       aclk;
    logic                       aresetn          = 1'b0;
    logic                       cfg_we           = 1'b0;
    logic [CFG_W-1:0]           cfg_wdata        = '0;
    logic                       s_valid          = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample         = '0;
    logic [CHAN_W-1:0]          s_channel        = '0;
    logic                       s_vector_end     = 1'b0;
    logic                       m_valid;
    logic                       m_ready          = 1'b0;
    logic signed [SAMPLE_W-1:0] m_average;
    logic [CHAN_W-1:0]          m_out_channel;
    logic                       m_out_vector_end;

    // Requests waiting to be sent and averages waiting to come back.
    sample_req_t  pending_req_q[$];
    average_res_t expected_avg_q[$];
    sample_req_t  sent_req;

    // Predicted filter state.
    logic signed [SAMPLE_W-1:0] avg_ring [WIN_MAX][NUM_CH];
    logic signed [SUM_W-1:0]    avg_sum [NUM_CH];
    int                         avg_fill;
    int                         avg_pos;
    int                         avg_win;

    // Shadow of the ring bookkeeping at generation time, so that no request
    // ever reads a ring entry that has never been written.
    bit gen_written [WIN_MAX][NUM_CH];
    int gen_fill;
    int gen_pos;
    int gen_win;

    int  n_sent;
    int  n_results;
    int  n_fail;
    int  n_writes;
    int  n_queued;
    int  send_idle;
    int  recv_idle;
    int  quiet_cycles;
    bit  steady;
    bit  long_hold_due;

    multichannel_moving_average_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_channel        (s_channel),
        .s_vector_end     (s_vector_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_average        (m_average),
        .m_out_channel    (m_out_channel),
        .m_out_vector_end (m_out_vector_end)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly short pauses, now and then a long one; none in steady phases.
    function automatic int draw_idle();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 45) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return 16'sh7FFF;
        end else if (r < 8) begin
            return 16'sh8000;
        end else if (r < 11) begin
            return 16'sh0000;
        end else if (r < 14) begin
            return 16'shFFFF;
        end else if (r < 40) begin
            return SAMPLE_W'($signed($urandom_range(0, 200)) - 100);
        end
        return SAMPLE_W'($urandom());
    endfunction

    // Work out the average that the block should return for one request.
    task automatic predict_average(input sample_req_t req);
        logic signed [SUM_W-1:0] total;
        logic                    full;
        int                      count;
        int                      quot;
        average_res_t            res;
        full  = avg_fill >= avg_win;
        total = avg_sum[req.channel];
        if (full) begin
            total = total - avg_ring[avg_pos][req.channel];
        end
        total = total + req.sample;
        avg_sum[req.channel]           = total;
        avg_ring[avg_pos][req.channel] = req.sample;
        count = full ? avg_win : avg_fill + 1;
        quot  = total / count;
        if (quot > AVG_POS_MAX) begin
            quot = AVG_POS_MAX;
        end
        if (quot < -AVG_NEG_MAX) begin
            quot = -AVG_NEG_MAX;
        end
        res.average    = SAMPLE_W'(quot);
        res.channel    = req.channel;
        res.vector_end = req.vector_end;
        expected_avg_q.push_back(res);
        if (req.vector_end) begin
            avg_pos = (avg_pos + 1 >= avg_win) ? 0 : avg_pos + 1;
            if (avg_fill < avg_win) begin
                avg_fill++;
            end
        end
    endtask

    // Queue one request, steering it away from a never-written ring entry.
    task automatic queue_req(input logic signed [SAMPLE_W-1:0] smp,
                             input logic [CHAN_W-1:0] ch, input logic vend);
        sample_req_t req;
        if (gen_fill >= gen_win && !gen_written[gen_pos][ch]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (gen_written[gen_pos][c]) begin
                    ch = CHAN_W'(c);
                end
            end
        end
        gen_written[gen_pos][ch] = 1'b1;
        if (vend) begin
            gen_pos = (gen_pos + 1 >= gen_win) ? 0 : gen_pos + 1;
            if (gen_fill < gen_win) begin
                gen_fill++;
            end
        end
        req.sample     = smp;
        req.channel    = ch;
        req.vector_end = vend;
        pending_req_q.push_back(req);
        n_queued++;
    endtask

    task automatic wait_idle();
        while (pending_req_q.size() != 0 || s_valid || expected_avg_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // A window write clears the sums, the fill count and the ring position.
    task automatic write_window(input logic [CFG_W-1:0] value);
        int w;
        wait_idle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        w = (value == 0) ? 1 : (value > WIN_MAX) ? WIN_MAX : int'(value);
        avg_win  = w;
        avg_fill = 0;
        avg_pos  = 0;
        for (int c = 0; c < NUM_CH; c++) begin
            avg_sum[c] = '0;
        end
        gen_win  = w;
        gen_fill = 0;
        gen_pos  = 0;
        n_writes++;
        @(negedge aclk);
    endtask

    // Sender: offers queued requests and predicts each one as it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_idle = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_average(sent_req);
                n_sent++;
                send_idle = draw_idle();
            end
            if (s_valid && !s_ready) begin
                // The request stays on the port until the block takes it.
            end else if (send_idle > 0) begin
                send_idle--;
                s_valid <= 1'b0;
            end else if (pending_req_q.size() != 0) begin
                sent_req = pending_req_q.pop_front();
                s_valid      <= 1'b1;
                s_sample     <= sent_req.sample;
                s_channel    <= sent_req.channel;
                s_vector_end <= sent_req.vector_end;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch on result %0d: expected %0d, got %0d",
                     $time, name, n_results, want, got);
            n_fail++;
        end
    endfunction

    // Receiver: checks every returned average and stalls at random.
    always @(posedge aclk) begin
        average_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_idle = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_avg_q.size() == 0) begin
                    $display("%0t ns: result with no request outstanding: average %0d",
                             $time, m_average);
                    n_fail++;
                end else begin
                    want = expected_avg_q.pop_front();
                    check_field("average", want.average, m_average);
                    check_field("channel", want.channel, m_out_channel);
                    check_field("vector end", want.vector_end, m_out_vector_end);
                end
                n_results++;
                recv_idle = draw_idle();
            end
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                recv_idle = LONG_HOLD;
            end
            if (recv_idle > 0) begin
                recv_idle--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long with work outstanding and no handshake on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else if (pending_req_q.size() != 0 || s_valid || expected_avg_q.size() != 0) begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("%0t ns: no progress for %0d cycles", $time, QUIET_MAX);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int                  ord [NUM_CH];
        int                  j;
        int                  t;
        int                  k;
        int                  n_vec;
        int                  pile_ch;
        logic [CFG_W-1:0]    wval;
        avg_win  = WINDOW_RESET;
        avg_fill = 0;
        avg_pos  = 0;
        gen_win  = WINDOW_RESET;
        gen_fill = 0;
        gen_pos  = 0;
        for (int c = 0; c < NUM_CH; c++) begin
            avg_sum[c] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default window: extremes, reversed channel order, negative truncation
        // and a vector with two channels missing.
        queue_req(16'sh7FFF, 2'd0, 1'b0);
        queue_req(16'sh8000, 2'd1, 1'b0);
        queue_req(16'sh0000, 2'd2, 1'b0);
        queue_req(16'shFFFF, 2'd3, 1'b1);
        queue_req(16'sh8000, 2'd3, 1'b0);
        queue_req(16'sh0001, 2'd2, 1'b0);
        queue_req(16'sh7FFF, 2'd1, 1'b0);
        queue_req(-16'sd3,   2'd0, 1'b1);
        queue_req(16'sd100,  2'd0, 1'b0);
        queue_req(-16'sd101, 2'd1, 1'b1);

        // A zero window is taken as one; a repeated channel drives the
        // quotient into both saturation limits.
        write_window(7'd0);
        queue_req(16'sh7FFF, 2'd2, 1'b0);
        queue_req(16'sh7FFF, 2'd2, 1'b0);
        queue_req(16'sh8000, 2'd2, 1'b0);
        queue_req(16'sh8000, 2'd2, 1'b0);
        queue_req(16'sh8000, 2'd2, 1'b0);
        queue_req(16'sd5,    2'd2, 1'b1);
        queue_req(-16'sd7,   2'd2, 1'b1);

        // An oversized window is taken as the largest one.
        write_window(7'd127);
        for (int c = 0; c < NUM_CH; c++) begin
            queue_req(16'sh7FFF, CHAN_W'(c), c == NUM_CH - 1);
        end
        for (int c = 0; c < NUM_CH; c++) begin
            queue_req(16'sh8000, CHAN_W'(c), c == NUM_CH - 1);
        end

        // One channel piled up within a single vector until its sum wraps.
        pile_ch = $urandom_range(0, NUM_CH - 1);
        for (int i = 0; i < 70; i++) begin
            queue_req(16'sh7FFF, CHAN_W'(pile_ch), 1'b0);
        end
        queue_req(draw_sample(), CHAN_W'(pile_ch), 1'b1);

        // Random phases, each under a fresh window setting.
        while (n_queued < ITEM_COUNT) begin
            case ($urandom_range(0, 9))
                0:       wval = 7'd0;
                1:       wval = 7'd127;
                2:       wval = 7'd64;
                3:       wval = 7'd65;
                4:       wval = CFG_W'($urandom_range(0, 127));
                default: wval = CFG_W'($urandom_range(1, 10));
            endcase
            write_window(wval);
            steady = ($urandom_range(0, 3) == 0);
            // Once, the receiver holds off for a long stretch while the
            // sender keeps requests coming, so that the block backs up.
            if (n_writes == 4) begin
                steady        = 1'b1;
                long_hold_due = 1'b1;
            end
            n_vec = gen_win + $urandom_range(2, 16);
            for (int v = 0; v < n_vec; v++) begin
                if ($urandom_range(0, 99) < 85) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        ord[c] = c;
                    end
                    for (int i = NUM_CH - 1; i > 0; i--) begin
                        j      = $urandom_range(0, i);
                        t      = ord[i];
                        ord[i] = ord[j];
                        ord[j] = t;
                    end
                    for (int c = 0; c < NUM_CH; c++) begin
                        queue_req(draw_sample(), CHAN_W'(ord[c]), c == NUM_CH - 1);
                    end
                end else begin
                    // Broken vector: missing or repeated channels, sometimes
                    // running on into the next vector without an end flag.
                    k = $urandom_range(1, 6);
                    for (int i = 0; i < k; i++) begin
                        queue_req(draw_sample(), CHAN_W'($urandom_range(0, NUM_CH - 1)),
                                  (i == k - 1) && ($urandom_range(0, 3) != 0));
                    end
                end
            end
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        if (expected_avg_q.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived",
                     $time, expected_avg_q.size());
            n_fail++;
        end
        $display("Sent %0d samples under %0d window settings; %0d averages compared.",
                 n_sent, n_writes + 1, n_results);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/mcma_pkg.sv
rtl/mcma_ram.sv
rtl/multichannel_moving_average_unit.sv
verif/tb.sv
